@@ rtl/b64e_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the Base64 alphabet for the stream encoder.
// No dependencies; the front, queue, back and core rtl files use this package by scoped names.
package b64e_pkg;

    localparam int unsigned SlotCount = 4;

    localparam logic [6:0] PadChar       = 7'd61;   // '='
    localparam logic [6:0] PlusChar      = 7'd43;   // '+'
    localparam logic [6:0] SlashChar     = 7'd47;   // '/'
    localparam logic [6:0] UpperOffset   = 7'd65;   // 'A' - 0
    localparam logic [6:0] LowerOffset   = 7'd71;   // 'a' - 26
    localparam logic [6:0] DigitOffset   = 7'd4;    // 52 - '0'

    localparam logic [5:0] LowerStart    = 6'd26;
    localparam logic [5:0] DigitStart    = 6'd52;
    localparam logic [5:0] PlusIndex     = 6'd62;

    // Position within the current 3-byte group
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } group_phase_t;

    // One classified byte: the characters it produces, in order
    typedef struct packed {
        logic [SlotCount-1:0][5:0] idx;        // 6-bit alphabet indices
        logic [SlotCount-1:0]      pad;        // slot carries '=' instead
        logic [1:0]                last_slot;  // index of the final slot
        logic                      fin;        // flag last slot as message end
    } job_t;

    // Handshake for a job moving between front, queue and back
    typedef struct packed {
        logic valid;
        job_t job;
    } job_beat_t;

    function automatic logic [6:0] b64_char(input logic [5:0] idx);
        logic [6:0] wide;
        wide = {1'b0, idx};
        if (idx < LowerStart) begin
            return wide + UpperOffset;
        end else if (idx < DigitStart) begin
            return wide + LowerOffset;
        end else if (idx < PlusIndex) begin
            return wide - DigitOffset;
        end else if (idx == PlusIndex) begin
            return PlusChar;
        end else begin
            return SlashChar;
        end
    endfunction

endpackage

@@ rtl/b64e_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw bytes in and Base64 characters out.
// No dependencies.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] code_char;
    logic       final_char;

    modport source (output valid, output code_char, output final_char, input ready);
    modport sink   (input valid, input code_char, input final_char, output ready);
endinterface

@@ rtl/b64e_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks group phase and carry bits, and turns each
// byte into a job of up to four characters. Depends on b64e_pkg.
module b64e_front (
    input  logic                clk,
    input  logic                rst_n,
    b64e_byte_if.sink           byte_stream,
    output b64e_pkg::job_beat_t push,
    input  logic                push_ready
);

    b64e_pkg::group_phase_t phase_reg, phase_next;
    logic [3:0]             carry_reg, carry_next;
    b64e_pkg::job_t         job;
    logic                   accept;

    assign byte_stream.ready = push_ready;
    assign accept            = byte_stream.valid && push_ready;
    assign push.valid        = byte_stream.valid;
    assign push.job          = job;

    always_comb
    begin
        job            = '0;
        job.fin        = byte_stream.final_byte;
        phase_next     = b64e_pkg::PH_FIRST;
        carry_next     = 4'd0;
        case (phase_reg)
            b64e_pkg::PH_SECOND:
            begin
                job.idx[0] = {carry_reg[1:0], byte_stream.data_byte[7:4]};
                if (byte_stream.final_byte)
                begin
                    job.idx[1]    = {byte_stream.data_byte[3:0], 2'b00};
                    job.pad       = 4'b0100;
                    job.last_slot = 2'd2;
                end
                else
                begin
                    job.last_slot = 2'd0;
                    phase_next    = b64e_pkg::PH_THIRD;
                    carry_next    = byte_stream.data_byte[3:0];
                end
            end
            b64e_pkg::PH_THIRD:
            begin
                job.idx[0]    = {carry_reg, byte_stream.data_byte[7:6]};
                job.idx[1]    = byte_stream.data_byte[5:0];
                job.last_slot = 2'd1;
            end
            default:
            begin
                // unused phase code behaves as the start of a group
                job.idx[0] = byte_stream.data_byte[7:2];
                if (byte_stream.final_byte)
                begin
                    job.idx[1]    = {byte_stream.data_byte[1:0], 4'b0000};
                    job.pad       = 4'b1100;
                    job.last_slot = 2'd3;
                end
                else
                begin
                    job.last_slot = 2'd0;
                    phase_next    = b64e_pkg::PH_SECOND;
                    carry_next    = {2'b00, byte_stream.data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64e_pkg::PH_FIRST;
            carry_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

@@ rtl/b64e_queue.sv @@
`timescale 1ns / 1ps
// Small job FIFO between the front and back ends.
// Depends on b64e_pkg for the job type.
module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  b64e_pkg::job_beat_t push,
    output logic                push_ready,
    output b64e_pkg::job_beat_t pop,
    input  logic                pop_ready
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64e_pkg::job_t      slots_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign pop.job    = slots_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

@@ rtl/b64e_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the slots of one job, maps each index to ASCII and drives
// the character channel from an output register. Depends on b64e_pkg.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64e_pkg::job_beat_t pop,
    output logic                pop_ready,
    b64e_char_if.source         char_stream
);

    logic           job_valid_reg, job_valid_next;
    b64e_pkg::job_t job_reg, job_next;
    logic [1:0]     slot_reg, slot_next;
    logic           out_valid_reg, out_valid_next;
    logic [6:0]     out_char_reg;
    logic           out_final_reg;
    logic           out_load;
    logic           last_slot;
    logic [6:0]     slot_char;

    assign char_stream.valid      = out_valid_reg;
    assign char_stream.code_char  = out_char_reg;
    assign char_stream.final_char = out_final_reg;

    assign out_load  = job_valid_reg && (!out_valid_reg || char_stream.ready);
    assign last_slot = (slot_reg == job_reg.last_slot);
    assign slot_char = job_reg.pad[slot_reg] ? b64e_pkg::PadChar
                                             : b64e_pkg::b64_char(job_reg.idx[slot_reg]);

    // take the next job when idle or when the current one issues its last beat
    assign pop_ready = !job_valid_reg || (out_load && last_slot);

    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && char_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            slot_next      = slot_reg + 1'b1;
        end
        if (pop_ready)
        begin
            job_valid_next = pop.valid;
            job_next       = pop.job;
            slot_next      = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (out_load)
        begin
            out_char_reg  <= slot_char;
            out_final_reg <= job_reg.fin && last_slot;
        end
    end

endmodule

@@ rtl/base64_stream_encoder_core.sv @@
`timescale 1ns / 1ps
// Channel      Dir  Payload                    Beat
// byte_stream  in   data_byte[7:0], final_byte one raw message byte
// char_stream  out  code_char[6:0], final_char one Base64 character or '='
//
// One byte is taken per cycle while the job queue has room; each byte turns
// into one to four characters, and the back end issues one character a cycle
// while it holds a job and char_stream is ready, so sustained input is set by
// the character port. A byte reaches char_stream through a queue slot, the job
// register and then the output register. Asynchronous active-low reset returns
// to the start of a group with an empty queue. A stalled char_stream fills the
// queue, after which byte_stream.ready drops.
// Depends on b64e_pkg, b64e_if, b64e_front, b64e_queue, b64e_back.
module base64_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if.sink   byte_stream,
    b64e_char_if.source char_stream
);

    b64e_pkg::job_beat_t push;
    b64e_pkg::job_beat_t pop;
    logic                push_ready;
    logic                pop_ready;

    b64e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .push        (push),
        .push_ready  (push_ready)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop         (pop),
        .pop_ready   (pop_ready),
        .char_stream (char_stream)
    );

endmodule

@@ tb/b64e_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the Base64 stream encoder: watches the byte and char channels,
// predicts the character stream and compares it beat by beat.
// Depends on b64e_pkg and b64e_if.
module b64e_checker (
    input  logic   clk,
    input  logic   rst_n,
    b64e_byte_if   byte_mon,
    b64e_char_if   char_mon,
    output int     fail_count,
    output int     pending_chars
);

    typedef struct packed {
        logic [6:0] code_char;
        logic       final_char;
    } char_beat_t;

    localparam logic [0:63][7:0] ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                             "abcdefghijklmnopqrstuvwxyz",
                                             "0123456789+/"};
    localparam logic [6:0] EQUALS = 7'd61;

    b64e_pkg::group_phase_t phase_q;
    logic [3:0]             carry_q;
    char_beat_t             expected_chars[$];

    function automatic logic [6:0] sextet_char(input logic [5:0] idx);
        return ALPHABET[idx][6:0];
    endfunction

    task automatic push_char(input logic [6:0] code, input logic last);
        char_beat_t beat;
        beat.code_char  = code;
        beat.final_char = last;
        expected_chars.push_back(beat);
    endtask

    // Advance the group position and queue the characters one byte produces
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        case (phase_q)
            b64e_pkg::PH_SECOND:
            begin
                push_char(sextet_char({carry_q[1:0], b[7:4]}), 1'b0);
                if (fin)
                begin
                    push_char(sextet_char({b[3:0], 2'b00}), 1'b0);
                    push_char(EQUALS, 1'b1);
                    phase_q = b64e_pkg::PH_FIRST;
                    carry_q = 4'd0;
                end
                else
                begin
                    phase_q = b64e_pkg::PH_THIRD;
                    carry_q = b[3:0];
                end
            end
            b64e_pkg::PH_THIRD:
            begin
                push_char(sextet_char({carry_q, b[7:6]}), 1'b0);
                push_char(sextet_char(b[5:0]), fin);
                phase_q = b64e_pkg::PH_FIRST;
                carry_q = 4'd0;
            end
            default:
            begin
                push_char(sextet_char(b[7:2]), 1'b0);
                if (fin)
                begin
                    push_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
                    push_char(EQUALS, 1'b0);
                    push_char(EQUALS, 1'b1);
                    phase_q = b64e_pkg::PH_FIRST;
                    carry_q = 4'd0;
                end
                else
                begin
                    phase_q = b64e_pkg::PH_SECOND;
                    carry_q = {2'b00, b[1:0]};
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        char_beat_t oldest;
        if (!rst_n)
        begin
            phase_q = b64e_pkg::PH_FIRST;
            carry_q = 4'd0;
            expected_chars.delete();
            fail_count = 0;
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
                encode_byte(byte_mon.data_byte, byte_mon.final_byte);
            if (char_mon.valid && char_mon.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected char beat: code_char %0d final_char %0b",
                           char_mon.code_char, char_mon.final_char);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_chars.pop_front();
                    if (char_mon.code_char !== oldest.code_char)
                    begin
                        $error("code_char mismatch: expected %0d actual %0d",
                               oldest.code_char, char_mon.code_char);
                        fail_count++;
                    end
                    if (char_mon.final_char !== oldest.final_char)
                    begin
                        $error("final_char mismatch: expected %0b actual %0b",
                               oldest.final_char, char_mon.final_char);
                        fail_count++;
                    end
                end
            end
        end
        pending_chars = expected_chars.size();
    end

endmodule

@@ tb/base64_stream_encoder_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the Base64 encoder testbench: clock, reset, byte stimulus and a
// stalling char receiver; the verdict comes from b64e_checker.
// Depends on b64e_pkg, b64e_if, base64_stream_encoder_core and b64e_checker.
module base64_stream_encoder_core_tb;

    typedef logic [7:0] byte_q_t[$];

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_chars;

    int   bytes_sent;
    int   burst_left;
    int   gap_max;
    int   run_max;
    int   stall_max;

    b64e_byte_if byte_in ();
    b64e_char_if char_out ();

    base64_stream_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_in),
        .char_stream (char_out)
    );

    b64e_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_mon      (byte_in),
        .char_mon      (char_out),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: ready runs and stalls of random length, bounded by the phase
    initial
    begin
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        char_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_max == 0)
                char_out.ready = 1'b1;
            else if (stall_left > 0)
            begin
                char_out.ready = 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                char_out.ready = 1'b1;
                run_left--;
            end
            else
            begin
                char_out.ready = 1'b1;
                run_left   = $urandom_range(0, run_max);
                stall_left = $urandom_range(0, stall_max);
            end
        end
    end

    // Hold valid within a burst; drop it only for a gap between bursts
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                byte_in.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        byte_in.valid      = 1'b1;
        byte_in.data_byte  = b;
        byte_in.final_byte = fin;
        do
            @(posedge clk);
        while (!byte_in.ready);
        @(negedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_message(input byte_q_t msg);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_random_message(input int len);
        byte_q_t msg;
        int      kind;
        for (int i = 0; i < len; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                msg.push_back(8'h00);
            else if (kind == 1)
                msg.push_back(8'hFF);
            else
                msg.push_back(8'($urandom));
        end
        send_message(msg);
    endtask

    task automatic drain;
        byte_in.valid = 1'b0;
        wait (pending_chars == 0);
        @(negedge clk);
    endtask

    initial
    begin
        int len;
        byte_in.valid      = 1'b0;
        byte_in.data_byte  = 8'h00;
        byte_in.final_byte = 1'b0;
        rst_n      = 1'b0;
        bytes_sent = 0;
        burst_left = 0;
        gap_max    = 0;
        run_max    = 8;
        stall_max  = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Flush from every group position, extremes, and the '+' '/' indexes
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'h80, 8'h01});
        send_message('{8'hFF, 8'hFF});
        send_message('{8'h4D, 8'h61, 8'h6E});
        send_message('{8'hFB, 8'hEF, 8'hFF});
        send_message('{8'h00, 8'h00, 8'h00, 8'hAA});
        send_message('{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h3C});
        send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

        // Hold off until the encoder has emitted everything
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin gap_max = 0;  stall_max = 0;  run_max = 8;  end
                1: begin gap_max = 3;  stall_max = 2;  run_max = 4;  end
                2: begin gap_max = 10; stall_max = 0;  run_max = 8;  end
                default: begin gap_max = 0;  stall_max = 12; run_max = 6;  end
            endcase
            while (bytes_sent < 25 + (phase + 1) * 110)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(20, 40);
                else
                    len = $urandom_range(1, 10);
                send_random_message(len);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ base64_stream_encoder_core.f @@
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_core.sv
tb/b64e_checker.sv
tb/base64_stream_encoder_core_tb.sv
